### src/key_event_scanner_fifo_defines.svh
// Assertion macros shared by the key event scanner checker.
`ifndef KEY_EVENT_SCANNER_FIFO_DEFINES_SVH
`define KEY_EVENT_SCANNER_FIFO_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define KES_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("key event scanner check failed");

// Same-cycle implication outside reset.
`define KES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("key event scanner check failed");

`endif

### src/kes_pkg.sv
// Shared types and constants for the key event scanner with event queue.
package kes_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int KEY_COUNT_DEF   = 6;
  localparam int LEVEL_W         = 6;
  localparam int CODE_W          = 8;
  localparam int COUNT_OUT_W     = 5;
  localparam int KEY_IDX_W       = 3;
  localparam int REQ_QUEUE_DEPTH = 2;

  localparam logic [LEVEL_W-1:0] ALL_KEYS_MASK = 6'h3F;
  localparam logic [CODE_W-1:0]  CODE_MAKE     = 8'h40;
  localparam logic [CODE_W-1:0]  CODE_BREAK    = 8'h80;
  localparam logic [CODE_W-1:0]  CODE_NONE     = 8'h00;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } back_state_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    cmd_e               cmd;
    logic [LEVEL_W-1:0] delta;
    logic [LEVEL_W-1:0] levels;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rq_stat_t;

endpackage

### src/kes_front.sv
// Front end: takes requests and turns scan samples into a change mask.
module kes_front #(
  parameter int KEY_COUNT = kes_pkg::KEY_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        command_i,
  input  logic [kes_pkg::LEVEL_W-1:0] key_levels_i,
  output kes_pkg::req_t               req_o
);
  import kes_pkg::*;

  localparam logic [LEVEL_W-1:0] LevelMask = ALL_KEYS_MASK >> (LEVEL_W - KEY_COUNT);

  logic [LEVEL_W-1:0] last_q, last_d;
  logic [LEVEL_W-1:0] now_levels;

  assign now_levels = key_levels_i & LevelMask;

  always_comb begin
    req_o.cmd    = cmd_e'(command_i);
    req_o.levels = now_levels;
    req_o.delta  = now_levels ^ last_q;
    last_d       = last_q;
    if (accept_i && (cmd_e'(command_i) == CMD_SCAN)) begin
      last_d = now_levels;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= LevelMask;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

### src/kes_req_queue.sv
// Two-entry request queue between the front end and the back end.
module kes_req_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kes_pkg::req_t     req_i,
  input  logic              pop_i,
  output kes_pkg::req_t     req_o,
  output kes_pkg::rq_stat_t stat_o
);
  import kes_pkg::*;

  localparam int PtrW = $clog2(REQ_QUEUE_DEPTH);
  localparam int CntW = $clog2(REQ_QUEUE_DEPTH + 1);

  req_t            slots_q [REQ_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CntW'(REQ_QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign req_o        = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(REQ_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(REQ_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### src/kes_back.sv
// Back end: walks the change mask into the event memory and serves pops.
module kes_back #(
  parameter int QUEUE_DEPTH = kes_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = kes_pkg::KEY_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kes_pkg::req_t                   req_i,
  input  kes_pkg::rq_stat_t               stat_i,
  output logic                            pop_o,
  output logic                            done_o,
  output logic [kes_pkg::CODE_W-1:0]      event_code_o,
  output logic                            event_valid_o,
  output logic [kes_pkg::COUNT_OUT_W-1:0] queue_count_o
);
  import kes_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  back_state_e            state_q, state_d;
  logic [KEY_IDX_W-1:0]   key_q, key_d;
  logic [LEVEL_W-1:0]     delta_q, delta_d;
  logic [LEVEL_W-1:0]     levels_q, levels_d;
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]        count_q, count_d;
  logic                   done_q, done_d;
  logic [CODE_W-1:0]      code_q, code_d;
  logic                   valid_q, valid_d;
  logic [COUNT_OUT_W-1:0] qcnt_q, qcnt_d;

  logic [CODE_W-1:0]      mem [QUEUE_DEPTH];
  logic [CODE_W-1:0]      rdata_q;
  logic                   wr_en, rd_en;
  logic [CODE_W-1:0]      wr_code;
  logic                   full;
  logic [PtrW+COUNT_OUT_W-1:0] count_ext;

  assign full          = (count_q == PtrW'(QUEUE_DEPTH - 1));
  assign wr_code       = (levels_q[key_q] ? CODE_BREAK : CODE_MAKE)
                         | {{(CODE_W-KEY_IDX_W){1'b0}}, key_q};
  assign count_ext     = {{COUNT_OUT_W{1'b0}}, count_d};
  assign done_o        = done_q;
  assign event_code_o  = code_q;
  assign event_valid_o = valid_q;
  assign queue_count_o = qcnt_q;

  always_comb begin
    state_d  = state_q;
    key_d    = key_q;
    delta_d  = delta_q;
    levels_d = levels_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    done_d   = 1'b0;
    code_d   = code_q;
    valid_d  = valid_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    pop_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          if (req_i.cmd == CMD_POP) begin
            if (count_q != '0) begin
              rd_en   = 1'b1;
              state_d = ST_POP;
            end else begin
              done_d  = 1'b1;
              code_d  = CODE_NONE;
              valid_d = 1'b0;
            end
          end else begin
            delta_d  = req_i.delta;
            levels_d = req_i.levels;
            key_d    = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // A changed key writes one code unless the queue is already full.
        if (delta_q[key_q] && !full) begin
          wr_en    = 1'b1;
          wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
          count_d  = count_q + 1'b1;
        end
        if (key_q == KEY_IDX_W'(KEY_COUNT - 1)) begin
          done_d  = 1'b1;
          code_d  = CODE_NONE;
          valid_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          key_d = key_q + 1'b1;
        end
      end
      ST_POP: begin
        done_d   = 1'b1;
        code_d   = rdata_q;
        valid_d  = 1'b1;
        rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
        count_d  = count_q - 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    qcnt_d = done_d ? count_ext[COUNT_OUT_W-1:0] : qcnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr_q] <= wr_code;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    delta_q  <= delta_d;
    levels_q <= levels_d;
    code_q   <= code_d;
    valid_q  <= valid_d;
    qcnt_q   <= qcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

endmodule

### src/key_event_scanner_fifo.sv
// Keypad make/break scanner with an event queue: top level.
//
// A request is taken at a rising edge with start high and busy low. With
// command_i low it is a scan sample of six active-low key levels; every key
// that changed since the last sample queues one code while the event queue has
// room, lowest key first (0x40 | key on press, 0x80 | key on release). With
// command_i high it pops the oldest code. Each request yields exactly one
// result, shown for one cycle with done_o high, together with the number of
// codes held after it. The receiver cannot stall; results come in request order.
// After a scan is accepted, the back end takes it from the request queue and
// then steps through the keys in order in its memory write loop; done_o is
// registered at the last key. A pop goes through a registered memory read
// before its result is shown; an empty pop is answered from idle. A two-entry
// request queue lets the front take requests while the back works, so busy
// rises only when it is full. The back end finishes each scan or pop before it
// takes the next request from the request queue.
// Reset empties the event queue and marks all keys released.
module key_event_scanner_fifo #(
  parameter int QUEUE_DEPTH = kes_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = kes_pkg::KEY_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command_i,
  input  logic [kes_pkg::LEVEL_W-1:0]     key_levels_i,
  output logic                            done_o,
  output logic [kes_pkg::CODE_W-1:0]      event_code_o,
  output logic                            event_valid_o,
  output logic [kes_pkg::COUNT_OUT_W-1:0] queue_count_o
);
  import kes_pkg::*;

  req_t     front_req;
  req_t     back_req;
  rq_stat_t rq_stat;
  logic     accept;
  logic     back_pop;

  assign busy   = rq_stat.full;
  assign accept = start && !rq_stat.full;

  kes_front #(
    .KEY_COUNT(KEY_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .key_levels_i(key_levels_i),
    .req_o       (front_req)
  );

  kes_req_queue u_req_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(accept),
    .req_i (front_req),
    .pop_i (back_pop),
    .req_o (back_req),
    .stat_o(rq_stat)
  );

  kes_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_COUNT  (KEY_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (back_req),
    .stat_i       (rq_stat),
    .pop_o        (back_pop),
    .done_o       (done_o),
    .event_code_o (event_code_o),
    .event_valid_o(event_valid_o),
    .queue_count_o(queue_count_o)
  );

endmodule

### src/kes_checker.sv
// Port-level checks for the key event scanner, bound to the top level.
`include "key_event_scanner_fifo_defines.svh"

module kes_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [kes_pkg::CODE_W-1:0]      event_code_o,
  input logic                            event_valid_o,
  input logic [kes_pkg::COUNT_OUT_W-1:0] queue_count_o
);
  import kes_pkg::*;

  logic code_none;
  logic code_form_ok;
  logic result_known;

  assign code_none    = (event_code_o == CODE_NONE);
  assign code_form_ok = (event_code_o[7] != event_code_o[6]) && (event_code_o[5:3] == 3'b000);
  assign result_known = !$isunknown(event_code_o) && !$isunknown(event_valid_o)
                        && !$isunknown(queue_count_o);

  // A result that returns no code carries code zero.
  `KES_ASSERT_IMP(a_empty_code_zero, clk_i, rst_ni, done_o && !event_valid_o, code_none)

  // A returned code is either a make or a break code for a key index.
  `KES_ASSERT_IMP(a_code_form, clk_i, rst_ni, done_o && event_valid_o, code_form_ok)

  // Straight after reset the block is ready and shows no result.
  `KES_ASSERT_IMP(a_reset_quiet, clk_i, rst_ni, $rose(rst_ni), !busy && !done_o)

  // The request queue only fills up after a request was taken.
  `KES_ASSERT_IMP(a_busy_needs_request, clk_i, rst_ni, $rose(busy), $past(start))

  // Every result carries fully defined fields.
  `KES_ASSERT_ALWAYS(a_result_known, clk_i, rst_ni, !done_o || result_known)

endmodule

bind key_event_scanner_fifo kes_checker u_kes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .event_code_o (event_code_o),
  .event_valid_o(event_valid_o),
  .queue_count_o(queue_count_o)
);
